>>> sv/assert_macros.svh
// Assertion helpers used by the block's top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ATRW_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("atrw assertion failed");
`define ATRW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atrw assertion failed");
`else
`define ATRW_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ATRW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/atrw_pkg.sv
`timescale 1ns / 1ps
package atrw_pkg;

    localparam int PRICE_WIDTH  = 32;
    localparam int PERIOD_WIDTH = 10;
    localparam int ADDR_WIDTH   = 3;
    localparam int DATA_WIDTH   = 32;
    localparam int CNT_WIDTH    = $clog2(PRICE_WIDTH);

    localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = PERIOD_WIDTH'(14);
    localparam logic [PERIOD_WIDTH-1:0] PERIOD_ONE   = PERIOD_WIDTH'(1);

    // register index, taken from paddr[2]
    localparam logic CFG_IDX_PERIOD = 1'b0;

    typedef logic [PRICE_WIDTH-1:0]  t_price;
    typedef logic [PERIOD_WIDTH-1:0] t_period;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MAX,
        ST_PREP,
        ST_START,
        ST_DIV,
        ST_STEP,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic diff;
        logic max;
        logic prep;
        logic start;
        logic step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic out_busy;
    } t_sts;

    function automatic t_price abs_diff(input t_price a, input t_price b);
        t_price d;
        d = (a >= b) ? (a - b) : (b - a);
        return d;
    endfunction

endpackage

>>> sv/atrw_div.sv
`timescale 1ns / 1ps
module atrw_div
    import atrw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_price  i_dividend,
    input  t_period i_divisor,
    output t_price  o_quotient,
    output t_period o_remainder,
    output logic    o_busy,
    output logic    o_done
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_WIDTH-1:0] r_cnt, n_cnt;
    t_price               r_quo, n_quo;
    t_period              r_rem, n_rem;

    logic [PERIOD_WIDTH:0] w_trial;
    logic                  w_fits;

    // restoring division, one quotient bit a cycle, MSB first
    assign w_trial = {r_rem, r_quo[PRICE_WIDTH-1]};
    assign w_fits  = (w_trial >= {1'b0, i_divisor});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_quo = {r_quo[PRICE_WIDTH-2:0], w_fits};
            n_rem = w_fits ? PERIOD_WIDTH'(w_trial - {1'b0, i_divisor})
                           : w_trial[PERIOD_WIDTH-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_WIDTH'(PRICE_WIDTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_busy      = r_busy;
    assign o_done      = r_done;

endmodule

>>> sv/atrw_dpath.sv
`timescale 1ns / 1ps
module atrw_dpath
    import atrw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    output t_sts    o_sts,
    input  t_period i_period,
    input  t_price  i_high_price,
    input  t_price  i_low_price,
    input  t_price  i_close_price,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_price  o_average_range
);

    // bar registers
    t_price  r_hi, r_lo, r_cl;
    t_price  r_hl, r_dh, r_dl;
    t_price  r_tr;
    t_price  r_mag;
    logic    r_neg, r_warm, r_seed;
    t_period r_divisor;
    t_price  r_step;

    // architectural state
    t_price  r_avg;
    t_price  r_last_close;
    logic    r_have_close;
    t_period r_bars;

    t_price  r_out;
    logic    r_out_valid;

    t_price  w_quo;
    t_period w_rem;
    logic    w_div_busy, w_div_done;
    t_period w_period_eff;
    logic    w_warm;
    t_price  w_max_a;

    atrw_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.start),
        .i_dividend  (r_mag),
        .i_divisor   (r_divisor),
        .o_quotient  (w_quo),
        .o_remainder (w_rem),
        .o_busy      (w_div_busy),
        .o_done      (w_div_done)
    );

    assign w_period_eff = (i_period == '0) ? PERIOD_ONE : i_period;
    assign w_warm       = (r_bars < w_period_eff);
    assign w_max_a      = (r_dh > r_hl) ? r_dh : r_hl;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_hi <= i_high_price;
            r_lo <= i_low_price;
            r_cl <= i_close_price;
        end
        if (i_cmd.diff) begin
            r_hl <= (r_hi >= r_lo) ? (r_hi - r_lo) : '0;
            r_dh <= r_have_close ? abs_diff(r_hi, r_last_close) : '0;
            r_dl <= r_have_close ? abs_diff(r_lo, r_last_close) : '0;
        end
        if (i_cmd.max) begin
            r_tr <= (r_dl > w_max_a) ? r_dl : w_max_a;
        end
        if (i_cmd.prep) begin
            r_neg     <= (r_tr < r_avg);
            r_mag     <= abs_diff(r_tr, r_avg);
            r_warm    <= w_warm;
            r_seed    <= (r_bars == '0);
            r_divisor <= w_warm ? (r_bars + PERIOD_ONE) : w_period_eff;
        end
        if (i_cmd.step) begin
            // warmup rounds a falling mean toward minus infinity
            r_step <= w_quo + PRICE_WIDTH'(r_neg && r_warm && (w_rem != '0));
        end
        if (i_cmd.commit) begin
            r_out <= r_seed ? r_tr : (r_neg ? (r_avg - r_step) : (r_avg + r_step));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg        <= '0;
            r_last_close <= '0;
            r_have_close <= 1'b0;
            r_bars       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_avg        <= r_seed ? r_tr
                                       : (r_neg ? (r_avg - r_step) : (r_avg + r_step));
                r_last_close <= r_cl;
                r_have_close <= 1'b1;
                if (r_warm) begin
                    r_bars <= r_bars + PERIOD_ONE;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.div_busy = w_div_busy;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_busy = r_out_valid && i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_average_range = r_out;

endmodule

>>> sv/atrw_ctrl.sv
`timescale 1ns / 1ps
module atrw_ctrl
    import atrw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_DIFF;
            ST_DIFF:   n_state = ST_MAX;
            ST_MAX:    n_state = ST_PREP;
            ST_PREP:   n_state = ST_START;
            ST_START:  n_state = ST_DIV;
            ST_DIV:    if (i_sts.div_done) n_state = ST_STEP;
            ST_STEP:   n_state = ST_COMMIT;
            ST_COMMIT: if (!i_sts.out_busy) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            ST_DIFF:   o_cmd.diff  = 1'b1;
            ST_MAX:    o_cmd.max   = 1'b1;
            ST_PREP:   o_cmd.prep  = 1'b1;
            ST_START:  o_cmd.start = 1'b1;
            ST_DIV:    o_cmd       = '0;
            ST_STEP:   o_cmd.step  = 1'b1;
            ST_COMMIT: o_cmd.commit = !i_sts.out_busy;
            default:   o_cmd       = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/average_true_range_wilder_unit.sv
`timescale 1ns / 1ps
// Average true range with Wilder smoothing, one price bar per item.
// Input channel: i_in_valid / o_in_stall with i_high_price, i_low_price and
// i_close_price (unsigned Q16.16). Output channel: o_out_valid / i_out_stall
// with o_average_range, one result item per input item, in order.
// An item is taken when valid is high and stall is low.
// After acceptance the item is worked through the states ST_DIFF, ST_MAX and
// ST_PREP for the range and difference, ST_START to start the divider, ST_DIV
// while the bit-serial divider runs (one quotient bit a cycle) and until it
// is seen to finish, ST_STEP to round and ST_COMMIT to commit.
// Only one item is in flight at a time; the next item is accepted in the
// cycle after the result goes into the output register.
// A stalled result holds in the output register; the following item is then
// worked up to its commit step and waits there until the result is taken.
// smoothing_period lies at APB address 0 (10 bits, reset 14); write it only
// while the block is idle.
// Reset (i_rst_n low, synchronous) clears the average, the last close and the
// bar count, so the next bar seeds the average again.
`include "assert_macros.svh"
module average_true_range_wilder_unit
    import atrw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_price                i_high_price,
    input  t_price                i_low_price,
    input  t_price                i_close_price,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_price                o_average_range
);

    t_period r_period;
    t_cmd    w_cmd;
    t_sts    w_sts;
    logic    w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (psel && penable && pwrite && (w_idx == CFG_IDX_PERIOD)) begin
            r_period <= pwdata[PERIOD_WIDTH-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_idx == CFG_IDX_PERIOD) begin
            prdata = DATA_WIDTH'(r_period);
        end
    end

    atrw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    atrw_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_period        (r_period),
        .i_high_price    (i_high_price),
        .i_low_price     (i_low_price),
        .i_close_price   (i_close_price),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_average_range (o_average_range)
    );

    // one item in flight at a time
    `ATRW_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // the divider is never left running while the block waits for an item
    `ATRW_ASSERT_ALWAYS(a_idle_div, i_clk, i_rst_n, o_in_stall || !w_sts.div_busy)
    // a commit never overwrites a result that is still stalled
    `ATRW_ASSERT_ALWAYS(a_no_overwrite, i_clk, i_rst_n, !(w_cmd.commit && o_out_valid && i_out_stall))

endmodule
